>>> src/radix64_armor_crc24_encoder_defines.svh
// Assertion macros used by the encoder back end.
`ifndef RADIX64_ARMOR_CRC24_ENCODER_DEFINES_SVH
`define RADIX64_ARMOR_CRC24_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define R64A_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r64a check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define R64A_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r64a check failed");

`endif

>>> src/r64a_pkg.sv
// Shared types, constants and functions of the radix-64 armor encoder.
package r64a_pkg;

    localparam int LINE_CHARS_DEF = 64;
    localparam int JOBQ_DEPTH_DEF = 4;

    localparam logic [23:0] CRC_INIT = 24'hB704CE;
    localparam logic [23:0] CRC_POLY = 24'h864CFB;   // 0x1864CFB without the x^24 term

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // Back-end step numbers
    localparam logic [2:0] STEP_GRP_LAST = 3'd3;   // last symbol of a group
    localparam logic [2:0] STEP_GRP_LF   = 3'd5;   // LF after a group
    localparam logic [2:0] STEP_CRC_LF   = 3'd6;   // LF ending the checksum line
    localparam logic [2:0] STEP_CR_GRP   = 3'd4;
    localparam logic [2:0] STEP_CR_CRC   = 3'd5;

    typedef enum logic {
        JOB_GROUP,
        JOB_CRC
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] value;
        logic [2:0]  nsym;    // symbols before '=' padding (2..4)
        logic        crlf;    // group closes its line
    } job_t;

    function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[23])
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[22:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        case (s) inside
            [6'd0:6'd25]:  c = 8'd65 + {2'b00, s};
            [6'd26:6'd51]: c = 8'd71 + {2'b00, s};        // 'a' - 26
            [6'd52:6'd61]: c = {2'b00, s} - 8'd4;         // '0' - 52
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

>>> src/r64a_front.sv
// Front end: takes message bytes, runs CRC-24, groups bytes into output jobs.
module r64a_front #(
    parameter int LINE_CHARS = r64a_pkg::LINE_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             jq_push,
    output r64a_pkg::job_t   jq_job,
    input  logic             jq_full
);

    localparam int GROUPS = LINE_CHARS / 4;
    localparam int GW     = $clog2(GROUPS + 1);

    logic [23:0]   crc_reg, crc_next;
    logic [15:0]   held_reg, held_next;
    logic [1:0]    hcnt_reg, hcnt_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic          pend_reg, pend_next;
    logic [23:0]   pcrc_reg, pcrc_next;

    logic          accept;
    logic [23:0]   crc_new;
    logic [GW-1:0] grp_inc;
    logic          job_vld;
    r64a_pkg::job_t grp_job;

    assign full    = jq_full || pend_reg;
    assign accept  = push && !full;
    assign crc_new = r64a_pkg::crc_byte(crc_reg, data_byte);
    assign grp_inc = grp_reg + GW'(1);

    always_comb
    begin
        crc_next      = crc_reg;
        held_next     = held_reg;
        hcnt_next     = hcnt_reg;
        grp_next      = grp_reg;
        pend_next     = pend_reg;
        pcrc_next     = pcrc_reg;
        job_vld       = 1'b0;
        grp_job.kind  = r64a_pkg::JOB_GROUP;
        grp_job.value = {held_reg, data_byte};
        grp_job.nsym  = 3'd4;
        grp_job.crlf  = 1'b0;

        if (pend_reg && !jq_full)
            pend_next = 1'b0;

        if (accept)
        begin
            crc_next = crc_new;
            if (hcnt_reg == 2'd2)
            begin
                job_vld      = 1'b1;
                hcnt_next    = 2'd0;
                held_next    = 16'h0000;
                grp_job.crlf = last_byte || (32'(grp_inc) >= GROUPS);
                grp_next     = (32'(grp_inc) >= GROUPS) ? '0 : grp_inc;
            end
            else if (last_byte)
            begin
                // partial group, padded
                job_vld      = 1'b1;
                grp_job.crlf = 1'b1;
                if (hcnt_reg == 2'd0)
                begin
                    grp_job.value = {data_byte, 16'h0000};
                    grp_job.nsym  = 3'd2;
                end
                else
                begin
                    grp_job.value = {held_reg[7:0], data_byte, 8'h00};
                    grp_job.nsym  = 3'd3;
                end
            end
            else
            begin
                held_next = {held_reg[7:0], data_byte};
                hcnt_next = hcnt_reg + 2'd1;
            end

            if (last_byte)
            begin
                crc_next  = r64a_pkg::CRC_INIT;
                held_next = 16'h0000;
                hcnt_next = 2'd0;
                grp_next  = '0;
                pend_next = 1'b1;
                pcrc_next = crc_new;
            end
        end
    end

    always_comb
    begin
        if (pend_reg)
        begin
            jq_push      = !jq_full;
            jq_job.kind  = r64a_pkg::JOB_CRC;
            jq_job.value = pcrc_reg;
            jq_job.nsym  = 3'd4;
            jq_job.crlf  = 1'b1;
        end
        else
        begin
            jq_push = job_vld;
            jq_job  = grp_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= r64a_pkg::CRC_INIT;
            held_reg <= 16'h0000;
            hcnt_reg <= 2'd0;
            grp_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            held_reg <= held_next;
            hcnt_reg <= hcnt_next;
            grp_reg  <= grp_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pcrc_reg <= pcrc_next;
    end

endmodule

>>> src/r64a_jobq.sv
// Short job queue between front end and back end.
module r64a_jobq #(
    parameter int DEPTH = r64a_pkg::JOBQ_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  r64a_pkg::job_t   wr_job,
    output logic             q_full,
    input  logic             rd_en,
    output r64a_pkg::job_t   rd_job,
    output logic             q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    r64a_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_wr, do_rd;

    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = entry_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        if (do_rd)
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wp_reg] <= wr_job;
    end

endmodule

>>> src/r64a_back.sv
// Back end: walks each job one character per cycle, room permitting, into a two-entry output queue.
`include "radix64_armor_crc24_encoder_defines.svh"

module r64a_back (
    input  logic             clk,
    input  logic             rst_n,
    input  r64a_pkg::job_t   job,
    input  logic             jq_empty,
    output logic             jq_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_char,
    output logic             last_char
);

    logic [2:0] step_reg, step_next;
    logic [7:0] ob_char_reg [2];
    logic       ob_last_reg [2];
    logic       ob_wp_reg, ob_wp_next;
    logic       ob_rp_reg, ob_rp_next;
    logic [1:0] ob_cnt_reg, ob_cnt_next;

    logic       out_pop;
    logic       emit;
    logic [2:0] last_step;
    logic [1:0] sidx;
    logic [5:0] sext;
    logic [7:0] ch;
    logic       fin;

    assign empty     = (ob_cnt_reg == 2'd0);
    assign out_pop   = pop && !empty;
    assign out_char  = ob_char_reg[ob_rp_reg];
    assign last_char = ob_last_reg[ob_rp_reg];

    assign emit      = !jq_empty && ((ob_cnt_reg != 2'd2) || out_pop);
    assign last_step = (job.kind == r64a_pkg::JOB_CRC) ? r64a_pkg::STEP_CRC_LF :
                       (job.crlf ? r64a_pkg::STEP_GRP_LF : r64a_pkg::STEP_GRP_LAST);
    assign jq_pop    = emit && (step_reg == last_step);

    // symbol index within the 24-bit value
    assign sidx = (job.kind == r64a_pkg::JOB_CRC) ? 2'(step_reg - 3'd1) : step_reg[1:0];

    always_comb
    begin
        case (sidx)
            2'd0:    sext = job.value[23:18];
            2'd1:    sext = job.value[17:12];
            2'd2:    sext = job.value[11:6];
            default: sext = job.value[5:0];
        endcase
    end

    always_comb
    begin
        fin = 1'b0;
        if (job.kind == r64a_pkg::JOB_CRC)
        begin
            if (step_reg == 3'd0)
                ch = r64a_pkg::CHAR_PAD;
            else if (step_reg == r64a_pkg::STEP_CR_CRC)
                ch = r64a_pkg::CHAR_CR;
            else if (step_reg == r64a_pkg::STEP_CRC_LF)
            begin
                ch  = r64a_pkg::CHAR_LF;
                fin = 1'b1;
            end
            else
                ch = r64a_pkg::b64_char(sext);
        end
        else
        begin
            if (step_reg == r64a_pkg::STEP_CR_GRP)
                ch = r64a_pkg::CHAR_CR;
            else if (step_reg == r64a_pkg::STEP_GRP_LF)
                ch = r64a_pkg::CHAR_LF;
            else if (step_reg < job.nsym)
                ch = r64a_pkg::b64_char(sext);
            else
                ch = r64a_pkg::CHAR_PAD;
        end
    end

    always_comb
    begin
        step_next   = step_reg;
        ob_wp_next  = ob_wp_reg;
        ob_rp_next  = ob_rp_reg;
        ob_cnt_next = ob_cnt_reg;
        if (emit)
        begin
            step_next  = jq_pop ? 3'd0 : step_reg + 3'd1;
            ob_wp_next = !ob_wp_reg;
        end
        if (out_pop)
            ob_rp_next = !ob_rp_reg;
        if (emit && !out_pop)
            ob_cnt_next = ob_cnt_reg + 2'd1;
        else if (out_pop && !emit)
            ob_cnt_next = ob_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 3'd0;
            ob_wp_reg  <= 1'b0;
            ob_rp_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            step_reg   <= step_next;
            ob_wp_reg  <= ob_wp_next;
            ob_rp_reg  <= ob_rp_next;
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_char_reg[ob_wp_reg] <= ch;
            ob_last_reg[ob_wp_reg] <= fin;
        end
    end

    // the final mark only ever rides on an LF
    `R64A_ASSERT_IMP(a_fin_is_lf, emit && fin, ch == r64a_pkg::CHAR_LF)
    // a group job never runs past its LF
    `R64A_ASSERT_IMP(a_grp_step, !jq_empty && job.kind == r64a_pkg::JOB_GROUP,
                     step_reg <= r64a_pkg::STEP_GRP_LF)
    // the step counter restarts after a job leaves the queue
    `R64A_ASSERT_NXT(a_step_restart, jq_pop, step_reg == 3'd0)
    // output queue never overflows
    `R64A_ASSERT_IMP(a_ob_room, emit, ob_cnt_reg != 2'd2 || out_pop)

endmodule

>>> src/radix64_armor_crc24_encoder.sv
// Top level of the radix-64 armor body encoder with CRC-24 checksum line.
// Streams message bytes in and ASCII armor characters out. Each byte request is
// taken by the front end when full is low; it runs the CRC-24 (init 0xB704CE,
// poly 0x1864CFB, MSB first) and packs every completed 3-byte group into a job
// for a small queue; the last byte also queues the final group, padded if
// partial, and a checksum job. The back end turns jobs into characters at one
// per cycle while the output queue has room: four base64 symbols per group,
// CR LF after each LINE_CHARS/4 groups and after the last partial line, then
// '=', four CRC symbols and CR LF, with last_char high on that final LF. Output
// throughput is therefore one character per cycle when unstalled, set by the
// back end; after a last byte, full stays high until its checksum job is queued.
// With both queues idle, a byte's job enters the job queue as the byte is
// accepted, then its first character enters the output queue, whose head drives
// the result ports. full rises when the job queue is full or a checksum job
// waits; the two-entry output queue lets the back end keep running while results
// wait. After the last byte the front end's CRC and grouping state is reset.
module radix64_armor_crc24_encoder #(
    parameter int LINE_CHARS = r64a_pkg::LINE_CHARS_DEF,
    parameter int JOBQ_DEPTH = r64a_pkg::JOBQ_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_char
);

    // front end to job queue
    logic           jq_push;
    r64a_pkg::job_t jq_wjob;
    logic           jq_full;

    // job queue to back end
    r64a_pkg::job_t jq_rjob;
    logic           jq_empty;
    logic           jq_pop;

    r64a_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .jq_push   (jq_push),
        .jq_job    (jq_wjob),
        .jq_full   (jq_full)
    );

    r64a_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (jq_push),
        .wr_job  (jq_wjob),
        .q_full  (jq_full),
        .rd_en   (jq_pop),
        .rd_job  (jq_rjob),
        .q_empty (jq_empty)
    );

    r64a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (jq_rjob),
        .jq_empty  (jq_empty),
        .jq_pop    (jq_pop),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

>>> tb/radix64_armor_crc24_encoder_test.sv
// Self-checking testbench for the radix-64 armor encoder with CRC-24 checksum line.
module radix64_armor_crc24_encoder_test;

    // Line length handed to the block; the checker works from the same value.
    localparam int LINE_CHARS      = 64;
    localparam int GROUPS_PER_LINE = LINE_CHARS / 4;   // partial groups never share a line

    // CRC-24: seed and feedback taps. The x^24 term is implied by the shift-out bit.
    localparam logic [23:0] CRC24_SEED = 24'hB704CE;
    localparam logic [23:0] CRC24_TAPS = 24'h864CFB;

    localparam logic [7:0] ASCII_PAD = 8'h3D;   // '='
    localparam logic [7:0] ASCII_CR  = 8'h0D;
    localparam logic [7:0] ASCII_LF  = 8'h0A;

    // Base64 alphabet, symbol 0 in the top byte.
    localparam logic [8*64-1:0] SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BYTES  = 500;
    // Room for what is still in flight; the pop side may also be stalled.
    localparam int TAIL_CYCLES   = 48;
    // Worst case: ~600 bytes x 13 chars x the longest pop stall, plus send gaps,
    // taken about four times over, at 4 time units per cycle.
    localparam int RUN_LIMIT     = 6_000_000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } armor_char_t;

    // One row of the directed table. 'shown' holds the leading characters this
    // request must produce where they are obvious by hand; empty means the
    // armor predictor supplies everything.
    typedef struct {
        logic [7:0] data;
        logic       fin;
        string      shown;
    } vector_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       empty;
    logic       pop       = 1'b0;
    logic [7:0] out_char;
    logic       last_char;

    // Armor predictor state: running CRC, bytes of the open group, groups on the line.
    logic [23:0] crc_run;
    logic [15:0] held;
    int          held_n;
    int          groups;

    armor_char_t step_chars[$];    // characters caused by the current request
    armor_char_t armor_due[$];     // characters still owed by the block, oldest first

    int errors        = 0;
    int bytes_sent    = 0;
    int messages      = 0;
    int chars_checked = 0;
    int lines_wrapped = 0;

    radix64_armor_crc24_encoder #(
        .LINE_CHARS(LINE_CHARS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char),
        .last_char(last_char)
    );

    always #2 clk = ~clk;

    // Hard stop in case a request or a character never shows up.
    initial
    begin
        #(RUN_LIMIT);
        $display("radix64_armor_crc24_encoder_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Armor predictor
    // ------------------------------------------------------------------

    function automatic void armor_reset();
        crc_run = CRC24_SEED;
        held    = 16'h0000;
        held_n  = 0;
        groups  = 0;
    endfunction

    function automatic void emit(input logic [7:0] c, input logic f);
        step_chars.push_back('{ch: c, fin: f});
    endfunction

    // Four characters of a 24-bit group; symbols past nsym become padding.
    function automatic void emit_group(input logic [23:0] v, input int nsym);
        logic [5:0] s;
        for (int i = 0; i < 4; i++)
        begin
            s = v[18 - 6 * i +: 6];
            if (i < nsym)
                emit(SYMBOLS[8 * (63 - s) +: 8], 1'b0);
            else
                emit(ASCII_PAD, 1'b0);
        end
    endfunction

    function automatic void emit_crlf(input logic f);
        emit(ASCII_CR, 1'b0);
        emit(ASCII_LF, f);
    endfunction

    // Works out every character one accepted byte causes and advances the state.
    function automatic void armor_byte(input logic [7:0] b, input logic fin);
        logic [23:0] c;
        c = crc_run ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[23])
                c = {c[22:0], 1'b0} ^ CRC24_TAPS;
            else
                c = {c[22:0], 1'b0};
        end
        crc_run = c;

        if (held_n == 2)
        begin
            emit_group({held, b}, 4);
            held   = 16'h0000;
            held_n = 0;
            groups++;
            if (groups >= GROUPS_PER_LINE)
            begin
                // wrap; also closes the line when this is the last byte
                emit_crlf(1'b0);
                groups = 0;
                lines_wrapped++;
            end
        end
        else
        begin
            held = {held[7:0], b};
            held_n++;
        end

        if (fin)
        begin
            if (held_n == 1)
            begin
                emit_group({held[7:0], 16'h0000}, 2);
                groups++;
            end
            else if (held_n == 2)
            begin
                emit_group({held, 8'h00}, 3);
                groups++;
            end
            if (groups > 0)
                emit_crlf(1'b0);
            emit(ASCII_PAD, 1'b0);
            emit_group(crc_run, 4);
            emit_crlf(1'b1);
            armor_reset();
        end
    endfunction

    // Gap length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one byte request after an idle gap of length 'gap' and holds it until taken.
    // push is written once per falling edge, so a back-to-back request never
    // sees it dropped and raised in the same step.
    task automatic send_byte(input logic [7:0] b, input logic fin, input string shown,
                             input int gap);
        armor_char_t c;
        @(negedge clk);
        repeat (gap)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (full);

        step_chars.delete();
        armor_byte(b, fin);
        // hand-written characters take the place of the predicted ones
        for (int k = 0; k < step_chars.size(); k++)
        begin
            c = step_chars[k];
            if (k < shown.len())
                c.ch = shown[k];
            armor_due.push_back(c);
        end
        bytes_sent++;
        if (fin)
            messages++;
    endtask

    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        vector_t vectors [DIRECTED_ROWS];
        int      random_sent;
        int      len;
        int      r;
        bit      steady;

        vectors = '{
            // single byte: one symbol pair and two pads
            '{8'h00, 1'b1, "AA=="},
            '{8'hFF, 1'b1, "/w=="},
            // two bytes: one pad
            '{8'hFF, 1'b0, ""},
            '{8'hFF, 1'b1, "//8="},
            // whole group closing the message: no padding
            '{8'h4D, 1'b0, ""},
            '{8'h61, 1'b0, ""},
            '{8'h6E, 1'b1, "TWFu"},
            // full group, then a one-byte tail
            '{8'hFF, 1'b0, ""},
            '{8'hFF, 1'b0, ""},
            '{8'hFF, 1'b0, "////"},
            '{8'h00, 1'b1, "AA=="},
            // full group, then a two-byte tail
            '{8'h00, 1'b0, ""},
            '{8'h00, 1'b0, ""},
            '{8'h00, 1'b0, "AAAA"},
            '{8'hFF, 1'b0, ""},
            '{8'hFF, 1'b1, "//8="},
            // the two punctuation symbols
            '{8'hFB, 1'b0, ""},
            '{8'hFF, 1'b0, ""},
            '{8'hBF, 1'b1, "+/+/"},
            // digits
            '{8'hD3, 1'b0, ""},
            '{8'h5D, 1'b0, ""},
            '{8'hB7, 1'b1, "0123"},
            // lower case
            '{8'h69, 1'b0, ""},
            '{8'hB7, 1'b0, ""},
            '{8'h1D, 1'b1, "abcd"}
        };

        armor_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (vectors[i])
            send_byte(vectors[i].data, vectors[i].fin, vectors[i].shown, pick_gap());

        // Random messages. Most are short; a fair share lands right around one
        // and two full lines so the wrap, including the wrap on the last byte,
        // comes up often. One message in four is sent without gaps.
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                len = $urandom_range(1, 6);
            else if (r < 80)
                len = $urandom_range(7, 20);
            else if (r < 93)
                len = $urandom_range(46, 51);
            else
                len = $urandom_range(94, 98);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_byte(random_byte(), i == len - 1, "", steady ? 0 : pick_gap());
            random_sent += len;
        end

        @(negedge clk);
        push <= 1'b0;

        while (armor_due.size() != 0)
            @(posedge clk);
        // let anything the block still has in flight come out and get flagged
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Encoded %0d messages (%0d bytes) with %0d full-line wraps;",
                 messages, bytes_sent, lines_wrapped);
        $display("checked %0d output characters, %0d mismatches.", chars_checked, errors);
        if (errors == 0)
            $display("radix64_armor_crc24_encoder_test: PASS");
        else
            $display("radix64_armor_crc24_encoder_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    function automatic void check_char();
        armor_char_t want;
        if (armor_due.size() == 0)
        begin
            $error("unexpected character: out_char=%h last_char=%b", out_char, last_char);
            errors++;
            return;
        end
        want = armor_due.pop_front();
        chars_checked++;
        if (out_char !== want.ch)
        begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            errors++;
        end
        if (last_char !== want.fin)
        begin
            $error("last_char: expected %b, got %b", want.fin, last_char);
            errors++;
        end
    endfunction

    // pop stalls at random; now and then the side switches into a steady
    // stretch where it takes a character every cycle whenever one is waiting.
    initial
    begin
        int stall;
        bit steady;
        stall  = 0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                steady = !steady;
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                if (!steady)
                    stall = pick_gap();
            end
            @(posedge clk);
            if (pop && !empty)
                check_char();
        end
    end

endmodule
